// File: hdl/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg
// Types, constants and register codes shared by the glyph bitmap converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gbr_pkg;

  localparam int MaxWidthDefault   = 4096;
  localparam int QueueDepthDefault = 4;

  // Width of column arithmetic: holds eight times the largest byte position.
  localparam int ColW = 18;

  localparam int PosW   = 14;
  localparam int PitchW = 15;
  localparam int WidthW = 13;
  localparam int ModeW  = 2;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  localparam logic [PitchW-1:0] PitchLimit = 15'd16384;

  localparam logic [1:0] RegMode  = 2'd0;
  localparam logic [1:0] RegWidth = 2'd1;
  localparam logic [1:0] RegPitch = 2'd2;

  typedef enum logic [ModeW-1:0] {
    MODE_GRAY = 2'd0,
    MODE_MONO = 2'd1,
    MODE_BGRA = 2'd2
  } pix_mode_e;

  typedef enum logic [1:0] {
    CMD_GRAY = 2'd0,
    CMD_MONO = 2'd1,
    CMD_BGRA = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [WidthW-1:0] width;
    logic [PitchW-1:0] pitch;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [23:0] bgr;
    logic [2:0]  last_idx;
    logic        row_end;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } upm_res_t;

  typedef struct packed {
    logic [7:0] src_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       last_of_run;
  } pixel_item_t;

endpackage

`default_nettype wire

// File: hdl/gbr_stream_if.sv
// ----------------------------------------------------------------------------
// gbr_stream_if
// Valid/ready stream channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbr_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/gbr_front.sv
// ----------------------------------------------------------------------------
// gbr_front
// Accepts source bytes, tracks the row position and turns the bytes that fall
// within the row width into pixel commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_front #(
  parameter int MAX_WIDTH = gbr_pkg::MaxWidthDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire gbr_pkg::cfg_t cfg_i,
  gbr_stream_if.sink        src_i,
  input  wire logic         q_full_i,
  output gbr_pkg::cmd_t     cmd_o,
  output logic              push_o
);

  localparam int CW = gbr_pkg::ColW;

  logic [gbr_pkg::PosW-1:0]   pos_q, pos_d;
  logic [23:0]                part_q, part_d;
  logic [CW-1:0]              w_eff, w_raw, first, col_b, pos_x, rem_m;
  logic [gbr_pkg::PitchW-1:0] pitch_eff, pos_n;
  logic                       accept, cmd_vld;
  logic [1:0]                 lane;

  assign src_i.ready = !q_full_i;
  assign accept      = src_i.valid && !q_full_i;

  assign w_raw     = CW'(cfg_i.width);
  assign w_eff     = (w_raw > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_raw;
  assign pitch_eff = (cfg_i.pitch == '0 || cfg_i.pitch > gbr_pkg::PitchLimit)
                     ? gbr_pkg::PitchLimit : cfg_i.pitch;
  assign pos_x     = CW'(pos_q);
  assign first     = CW'({pos_q, 3'b000});
  assign col_b     = CW'(pos_q[gbr_pkg::PosW-1:2]);
  assign rem_m     = w_eff - first;
  assign lane      = pos_q[1:0];
  assign pos_n     = gbr_pkg::PitchW'(pos_q) + 15'd1;

  always_comb begin
    cmd_o.kind     = gbr_pkg::CMD_GRAY;
    cmd_o.data     = src_i.data.src_byte;
    cmd_o.bgr      = part_q;
    cmd_o.last_idx = 3'd0;
    cmd_o.row_end  = 1'b0;
    cmd_vld        = 1'b0;
    part_d         = part_q;
    unique case (cfg_i.mode)
      gbr_pkg::MODE_GRAY: begin
        cmd_vld       = pos_x < w_eff;
        cmd_o.row_end = (pos_x + CW'(1)) == w_eff;
      end
      gbr_pkg::MODE_MONO: begin
        cmd_o.kind = gbr_pkg::CMD_MONO;
        cmd_vld    = first < w_eff;
        if (rem_m >= CW'(8)) begin
          cmd_o.last_idx = 3'd7;
          cmd_o.row_end  = rem_m == CW'(8);
        end else begin
          cmd_o.last_idx = 3'(rem_m - CW'(1));
          cmd_o.row_end  = 1'b1;
        end
      end
      gbr_pkg::MODE_BGRA: begin
        cmd_o.kind    = gbr_pkg::CMD_BGRA;
        cmd_o.row_end = (col_b + CW'(1)) == w_eff;
        if (lane == 2'd3) begin
          cmd_vld = col_b < w_eff;
        end else begin
          part_d[8*lane +: 8] = src_i.data.src_byte;
        end
      end
      default: begin
        cmd_vld = 1'b0;
      end
    endcase
    if (pos_n >= pitch_eff) begin
      pos_d  = '0;
      part_d = '0;
    end else begin
      pos_d = pos_n[gbr_pkg::PosW-1:0];
    end
  end

  assign push_o = accept && cmd_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      part_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      part_q <= part_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/gbr_fifo.sv
// ----------------------------------------------------------------------------
// gbr_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_fifo #(
  parameter int DEPTH = gbr_pkg::QueueDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire gbr_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output gbr_pkg::cmd_t      cmd_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  gbr_pkg::cmd_t    mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CNW-1:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/gbr_unpremul.sv
// ----------------------------------------------------------------------------
// gbr_unpremul
// Iterative un-premultiply unit: three restoring dividers sharing one
// divisor, one quotient bit per cycle, saturating at 255.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_unpremul (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [7:0]   alpha_i,
  input  wire logic [23:0]  bgr_i,
  output logic              busy_o,
  output gbr_pkg::upm_res_t res_o
);

  logic        busy_q;
  logic [2:0]  cnt_q;
  logic [16:0] dsh_q;
  logic        aza_q;
  logic [16:0] rem_q [3];
  logic [7:0]  quo_q [3];
  logic [2:0]  sat_q;
  logic [7:0]  chan  [3];

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 3'd7;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [7:0]  c;
    logic [16:0] n;
    logic [8:0]  d;
    d = {alpha_i, 1'b0};
    if (start_i) begin
      aza_q <= alpha_i == 8'd0;
      dsh_q <= {1'b0, d, 7'b0};
      for (int ch = 0; ch < 3; ch++) begin
        c = bgr_i[8*ch +: 8];
        n = (17'(c) << 9) - (17'(c) << 1) + 17'(alpha_i);
        rem_q[ch] <= n;
        quo_q[ch] <= '0;
        sat_q[ch] <= (alpha_i == 8'd0) ? (c != 8'd0) : (n >= {d, 8'b0});
      end
    end else if (busy_q) begin
      dsh_q <= dsh_q >> 1;
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_q[ch] >= dsh_q) begin
          rem_q[ch] <= rem_q[ch] - dsh_q;
          quo_q[ch] <= {quo_q[ch][6:0], 1'b1};
        end else begin
          quo_q[ch] <= {quo_q[ch][6:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      chan[ch] = sat_q[ch] ? 8'd255 : (aza_q ? 8'd0 : quo_q[ch]);
    end
    res_o.blue  = chan[0];
    res_o.green = chan[1];
    res_o.red   = chan[2];
  end

endmodule

`default_nettype wire

// File: hdl/gbr_back.sv
// ----------------------------------------------------------------------------
// gbr_back
// Executes pixel commands: expands gray and mono bytes into pixels, runs the
// un-premultiply unit for BGRA, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire gbr_pkg::cmd_t q_cmd_i,
  output logic               pop_o,
  gbr_stream_if.source       pix_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [2:0]           idx_q, idx_d;
  gbr_pkg::cmd_t        cmd_q, cmd_d;
  logic                 ovalid_q, ovalid_d;
  gbr_pkg::pixel_item_t opix_q, opix_d;
  logic                 out_free, free, div_start, div_busy, last;
  gbr_pkg::upm_res_t    div_res;

  gbr_unpremul u_upm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .alpha_i (q_cmd_i.data),
    .bgr_i   (q_cmd_i.bgr),
    .busy_o  (div_busy),
    .res_o   (div_res)
  );

  assign out_free    = !ovalid_q || pix_o.ready;
  assign last        = idx_q == cmd_q.last_idx;
  assign pix_o.valid = ovalid_q;
  assign pix_o.data  = opix_q;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_d     = cmd_q;
    ovalid_d  = ovalid_q && !pix_o.ready;
    opix_d    = opix_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    free      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        free = 1'b1;
      end
      ST_RUN: begin
        if (out_free) begin
          ovalid_d           = 1'b1;
          opix_d.red         = 8'd255;
          opix_d.green       = 8'd255;
          opix_d.blue        = 8'd255;
          opix_d.row_end     = last && cmd_q.row_end;
          opix_d.last_of_run = last;
          if (cmd_q.kind == gbr_pkg::CMD_MONO) begin
            opix_d.alpha = cmd_q.data[3'd7 - idx_q] ? 8'd255 : 8'd0;
          end else begin
            opix_d.alpha = cmd_q.data;
          end
          if (last) begin
            free = 1'b1;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      ST_DIV: begin
        if (out_free && !div_busy) begin
          ovalid_d           = 1'b1;
          opix_d.red         = div_res.red;
          opix_d.green       = div_res.green;
          opix_d.blue        = div_res.blue;
          opix_d.alpha       = cmd_q.data;
          opix_d.row_end     = cmd_q.row_end;
          opix_d.last_of_run = 1'b1;
          free               = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (free) begin
      if (q_valid_i) begin
        pop_o = 1'b1;
        cmd_d = q_cmd_i;
        idx_d = 3'd0;
        if (q_cmd_i.kind == gbr_pkg::CMD_BGRA) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_RUN;
        end
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    opix_q <= opix_d;
  end

endmodule

`default_nettype wire

// File: hdl/glyph_bitmap_to_rgba.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_to_rgba
// Converts a glyph bitmap, one source byte per item, into straight-alpha
// RGBA pixels in gray, mono and premultiplied BGRA modes.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   src_i    in         valid/ready          src_byte
//   pix_o    out        valid/ready          red, green, blue, alpha,
//                                            row_end, last_of_run
//   APB      in         psel/penable/pready  mode, row_width, row_pitch
//
// A byte is accepted while the command queue has room.
// Gray pixels leave at one per cycle and mono bytes at one pixel per cycle,
// when the output is not stalled. A BGRA pixel holds the back end through
// the eight-step un-premultiply dividers and the output register load.
// Reset clears the row position and the queue; no clearing pass is needed.
// The queue lets byte intake continue while the output register is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_bitmap_to_rgba #(
  parameter int MAX_WIDTH   = gbr_pkg::MaxWidthDefault,
  parameter int QUEUE_DEPTH = gbr_pkg::QueueDepthDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  gbr_stream_if.sink                     src_i,
  gbr_stream_if.source                   pix_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [gbr_pkg::AddrW-1:0] paddr,
  input  wire logic [gbr_pkg::DataW-1:0] pwdata,
  output logic      [gbr_pkg::DataW-1:0] prdata,
  output logic                           pready
);

  gbr_pkg::cfg_t cfg_q;
  gbr_pkg::cmd_t f_cmd, q_cmd;
  logic          push, q_full, q_valid, pop, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= gbr_pkg::MODE_GRAY;
      cfg_q.width <= 13'd1;
      cfg_q.pitch <= 15'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        gbr_pkg::RegMode:  cfg_q.mode  <= pwdata[gbr_pkg::ModeW-1:0];
        gbr_pkg::RegWidth: cfg_q.width <= pwdata[gbr_pkg::WidthW-1:0];
        gbr_pkg::RegPitch: cfg_q.pitch <= pwdata[gbr_pkg::PitchW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      gbr_pkg::RegMode:  prdata = gbr_pkg::DataW'(cfg_q.mode);
      gbr_pkg::RegWidth: prdata = gbr_pkg::DataW'(cfg_q.width);
      gbr_pkg::RegPitch: prdata = gbr_pkg::DataW'(cfg_q.pitch);
      default:           prdata = '0;
    endcase
  end

  gbr_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .src_i    (src_i),
    .q_full_i (q_full),
    .cmd_o    (f_cmd),
    .push_o   (push)
  );

  gbr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  gbr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .pix_o     (pix_o)
  );

endmodule

`default_nettype wire
